FILE: hdl/cursor_list_dictionary_assert.svh
// assertion helpers for the cursor list dictionary
`ifndef CURSOR_LIST_DICTIONARY_ASSERT_SVH
`define CURSOR_LIST_DICTIONARY_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CLD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cursor_list_dictionary assertion failed");

// next-cycle implication, disabled in reset
`define CLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cursor_list_dictionary assertion failed");

`endif

FILE: hdl/cld_pkg.sv
`timescale 1ns / 1ps

package cld_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int KEY_W = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_INS_RD,
      S_WALK,
      S_REM_FIX,
      S_REM_FREE,
      S_RESP
   } state_type;

endpackage

FILE: hdl/cld_ram.sv
`timescale 1ns / 1ps

module cld_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = cld_pkg::CAPACITY_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/cursor_list_dictionary.sv
`timescale 1ns / 1ps
// from accept to rsp_tvalid: insert passes S_INS_RD, then S_RESP; a full pool or an unused
// operation goes straight to S_RESP; query and remove walk S_WALK up to the first match (the
// list end on a miss, none on an empty list), and a remove match adds S_REM_FIX, S_REM_FREE
// before S_RESP; words are taken one at a time, only in S_IDLE, and the list walk follows one
// link per cycle through the link and key memories
// reset: synchronous; a clearing pass over every slot chains the free list, req_tready low
`include "cursor_list_dictionary_assert.svh"

module cursor_list_dictionary #(
   parameter int CAPACITY = cld_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] search_key
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [1:0] status, [7:2] zero
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int PTR_W = $clog2(CAPACITY + 1);
   localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   cld_pkg::state_type state_ff, state_in;

   logic signed [cld_pkg::KEY_W-1:0] key_ff, key_in;
   logic [1:0]       op_ff, op_in;
   logic [PTR_W-1:0] cur_ff, cur_in;
   logic [PTR_W-1:0] prev_ff, prev_in;
   logic [PTR_W-1:0] next_ff, next_in;
   logic [PTR_W-1:0] used_head_ff, used_head_in;
   logic [PTR_W-1:0] free_head_ff, free_head_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [1:0]       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;

   logic             key_we;
   logic [IDX_W-1:0] key_waddr;
   logic             link_we;
   logic [IDX_W-1:0] link_waddr;
   logic [PTR_W-1:0] link_wdata;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [cld_pkg::KEY_W-1:0] key_rdata;
   logic [PTR_W-1:0] link_rdata;

   cld_ram #(
      .WIDTH (cld_pkg::KEY_W),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rdata)
   );

   cld_ram #(
      .WIDTH (PTR_W),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (link_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cld_pkg::S_CLEAR;
         used_head_ff  <= NIL;
         free_head_ff  <= '0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_head_ff  <= used_head_in;
         free_head_ff  <= free_head_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      key_ff        <= key_in;
      op_ff         <= op_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      op_in         = op_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      used_head_in  = used_head_ff;
      free_head_in  = free_head_ff;
      clr_in        = clr_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      req_tready    = 1'b0;
      key_we        = 1'b0;
      key_waddr     = cur_ff[IDX_W-1:0];
      link_we       = 1'b0;
      link_waddr    = cur_ff[IDX_W-1:0];
      link_wdata    = free_head_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_ff[IDX_W-1:0];

      unique case (state_ff)
         cld_pkg::S_CLEAR: begin
            // chain slot i to i + 1, the last slot ends at nil
            link_we    = 1'b1;
            link_waddr = clr_ff;
            link_wdata = PTR_W'(clr_ff) + PTR_W'(1);
            clr_in     = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = cld_pkg::S_IDLE;
            end
         end
         cld_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in  = req_tdata;
               op_in   = req_tuser;
               prev_in = NIL;
               unique case (req_tuser)
                  cld_pkg::OP_INSERT: begin
                     if (free_head_ff < NIL) begin
                        rd_en    = 1'b1;
                        rd_addr  = free_head_ff[IDX_W-1:0];
                        cur_in   = free_head_ff;
                        state_in = cld_pkg::S_INS_RD;
                     end else begin
                        status_in = cld_pkg::ST_FULL;
                        state_in  = cld_pkg::S_RESP;
                     end
                  end
                  cld_pkg::OP_QUERY, cld_pkg::OP_REMOVE: begin
                     if (used_head_ff < NIL) begin
                        rd_en    = 1'b1;
                        rd_addr  = used_head_ff[IDX_W-1:0];
                        cur_in   = used_head_ff;
                        state_in = cld_pkg::S_WALK;
                     end else begin
                        status_in = cld_pkg::ST_MISSING;
                        state_in  = cld_pkg::S_RESP;
                     end
                  end
                  default: begin
                     status_in = cld_pkg::ST_MISSING;
                     state_in  = cld_pkg::S_RESP;
                  end
               endcase
            end
         end
         cld_pkg::S_INS_RD: begin
            // link_rdata is the successor of the popped free slot
            key_we       = 1'b1;
            link_we      = 1'b1;
            link_wdata   = used_head_ff;
            free_head_in = link_rdata;
            used_head_in = cur_ff;
            status_in    = cld_pkg::ST_OK;
            state_in     = cld_pkg::S_RESP;
         end
         cld_pkg::S_WALK: begin
            if (key_rdata == key_ff) begin
               if (op_ff == cld_pkg::OP_REMOVE) begin
                  next_in  = link_rdata;
                  state_in = cld_pkg::S_REM_FIX;
               end else begin
                  status_in = cld_pkg::ST_OK;
                  state_in  = cld_pkg::S_RESP;
               end
            end else if (link_rdata < NIL) begin
               // follow the link straight from the registered read
               rd_en   = 1'b1;
               rd_addr = link_rdata[IDX_W-1:0];
               prev_in = cur_ff;
               cur_in  = link_rdata;
            end else begin
               status_in = cld_pkg::ST_MISSING;
               state_in  = cld_pkg::S_RESP;
            end
         end
         cld_pkg::S_REM_FIX: begin
            if (prev_ff < NIL) begin
               link_we    = 1'b1;
               link_waddr = prev_ff[IDX_W-1:0];
               link_wdata = next_ff;
            end else begin
               used_head_in = next_ff;
            end
            state_in = cld_pkg::S_REM_FREE;
         end
         cld_pkg::S_REM_FREE: begin
            link_we      = 1'b1;
            link_wdata   = free_head_ff;
            free_head_in = cur_ff;
            status_in    = cld_pkg::ST_OK;
            state_in     = cld_pkg::S_RESP;
         end
         cld_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = cld_pkg::S_IDLE;
            end
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff};

   `CLD_ASSERT_NOW(a_no_accept_in_clear, clock, reset, state_ff == cld_pkg::S_CLEAR, !req_tready)
   `CLD_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready, state_ff != cld_pkg::S_IDLE)
   `CLD_ASSERT_NOW(a_walk_ptr_valid, clock, reset, state_ff == cld_pkg::S_WALK, cur_ff < NIL)
   `CLD_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, rsp_tdata[1:0] != 2'd3)

endmodule

FILE: test/cld_checker.sv
`timescale 1ns / 1ps

module cld_checker #(
   parameter int CAPACITY = cld_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] search_key
   input  logic [1:0]  req_tuser,   // [1:0] operation
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [1:0] status, [7:2] zero
   output int          fail_count,
   output int          awaiting
);

   localparam int LINK_W = $clog2(CAPACITY + 1);
   typedef logic [LINK_W-1:0] slot_type;
   localparam slot_type NIL = slot_type'(CAPACITY);

   logic [cld_pkg::KEY_W-1:0] slot_key [CAPACITY];
   slot_type         slot_next [CAPACITY];
   slot_type         used_first;
   slot_type         free_first;
   logic [1:0]       status_due [$];
   logic [1:0]       due;

   // applies one word to the shadow pool and returns the status it should answer
   function automatic logic [1:0] dictionary_outcome(logic [1:0] op,
                                                     logic [cld_pkg::KEY_W-1:0] key);
      slot_type cur;
      slot_type prev;
      slot_type grabbed;
      int       steps;
      case (op)
         cld_pkg::OP_INSERT: begin
            if (!(free_first < CAPACITY)) return cld_pkg::ST_FULL;
            grabbed = free_first;
            free_first = slot_next[grabbed];
            slot_key[grabbed] = key;
            slot_next[grabbed] = used_first;
            used_first = grabbed;
            return cld_pkg::ST_OK;
         end
         cld_pkg::OP_QUERY: begin
            cur = used_first;
            for (steps = 0; steps < CAPACITY && cur < CAPACITY; steps++) begin
               if (slot_key[cur] == key) return cld_pkg::ST_OK;
               cur = slot_next[cur];
            end
            return cld_pkg::ST_MISSING;
         end
         cld_pkg::OP_REMOVE: begin
            cur = used_first;
            prev = NIL;
            for (steps = 0; steps < CAPACITY && cur < CAPACITY; steps++) begin
               if (slot_key[cur] == key) begin
                  // unlink, then push the slot on the free list front
                  if (prev < CAPACITY) slot_next[prev] = slot_next[cur];
                  else used_first = slot_next[cur];
                  slot_next[cur] = free_first;
                  free_first = cur;
                  return cld_pkg::ST_OK;
               end
               prev = cur;
               cur = slot_next[cur];
            end
            return cld_pkg::ST_MISSING;
         end
         default: return cld_pkg::ST_MISSING;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) begin
            slot_key[i] = '0;
            slot_next[i] = slot_type'(i + 1);
         end
         used_first = NIL;
         free_first = '0;
         status_due.delete();
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            status_due.push_back(dictionary_outcome(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (status_due.size() == 0) begin
               $error("rsp word with nothing pending, status %0d", rsp_tdata[1:0]);
               fail_count++;
            end else begin
               due = status_due.pop_front();
               if (rsp_tdata[1:0] !== due) begin
                  $error("field status mismatch: expected %0d, actual %0d", due, rsp_tdata[1:0]);
                  fail_count++;
               end
            end
         end
      end
      awaiting = status_due.size();
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int POOL_KEYS = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [7:0]  rsp_tdata;
   int          fail_count;
   int          awaiting;
   int          gap_pct = 0;
   int          stall_pct = 0;
   logic [31:0] key_pool [POOL_KEYS];

   cursor_list_dictionary dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cld_checker watch (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .awaiting   (awaiting)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_word(logic [1:0] op, logic [31:0] key);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid = 1'b0;
         req_tdata = $urandom;
         req_tuser = 2'($urandom_range(0, 3));
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // hold off the sender until every pending status has come back
   task automatic drain_pending();
      req_tvalid = 1'b0;
      while (awaiting != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, POOL_KEYS - 1)];
      return $urandom;
   endfunction

   task automatic run_phase(int words, int ins_pct, int qry_pct, int rem_pct);
      int r;
      logic [1:0] op;
      for (int n = 0; n < words; n++) begin
         r = $urandom_range(0, 99);
         if (r < ins_pct) op = cld_pkg::OP_INSERT;
         else if (r < ins_pct + qry_pct) op = cld_pkg::OP_QUERY;
         else if (r < ins_pct + qry_pct + rem_pct) op = cld_pkg::OP_REMOVE;
         else op = OP_UNUSED;
         send_word(op, pick_key());
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list first, then extremes placed at head, middle and tail
      send_word(cld_pkg::OP_QUERY,  32'h0000_0000);
      send_word(cld_pkg::OP_REMOVE, 32'h0000_0000);
      send_word(cld_pkg::OP_INSERT, 32'h0000_0000);
      send_word(cld_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_word(cld_pkg::OP_INSERT, 32'h8000_0000);
      send_word(cld_pkg::OP_INSERT, 32'h7FFF_FFFF);
      send_word(cld_pkg::OP_QUERY,  32'hFFFF_FFFF);
      send_word(cld_pkg::OP_QUERY,  32'h1234_5678);
      send_word(cld_pkg::OP_REMOVE, 32'h8000_0000);
      send_word(cld_pkg::OP_REMOVE, 32'h7FFF_FFFF);
      send_word(cld_pkg::OP_REMOVE, 32'h0000_0000);
      send_word(cld_pkg::OP_REMOVE, 32'h0000_0000);
      send_word(cld_pkg::OP_QUERY,  32'h0000_0000);
      // duplicates: first remove leaves the second copy
      send_word(cld_pkg::OP_INSERT, 32'h0000_0005);
      send_word(cld_pkg::OP_INSERT, 32'h0000_0005);
      send_word(cld_pkg::OP_REMOVE, 32'h0000_0005);
      send_word(cld_pkg::OP_QUERY,  32'h0000_0005);
      send_word(cld_pkg::OP_REMOVE, 32'h0000_0005);
      send_word(cld_pkg::OP_QUERY,  32'h0000_0005);
      send_word(OP_UNUSED,          32'hFFFF_FFFF);
      send_word(cld_pkg::OP_QUERY,  32'hFFFF_FFFF);
      drain_pending();

      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < POOL_KEYS; i++) key_pool[i] = $urandom;

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 57; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 57; end
            default: begin gap_pct = 16; stall_pct = 16; end
         endcase
         // fill to a full pool, mix, then drain toward empty
         case (ph % 3)
            0: run_phase(150, 80, 8, 8);
            1: run_phase(150, 40, 30, 25);
            default: run_phase(150, 15, 30, 50);
         endcase
         drain_pending();
         for (int i = 4; i < POOL_KEYS; i += 3) key_pool[i] = $urandom;
      end

      gap_pct = 0;
      drain_pending();
      repeat (cld_pkg::CAPACITY_DEFAULT + 8) @(negedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/cld_pkg.sv
hdl/cld_ram.sv
hdl/cursor_list_dictionary.sv
test/cld_checker.sv
test/tb_top.sv
